/* src/dtcf_pkg.sv */
// Shared types, constants and helper functions for the debug trace character FIFO.
`default_nettype none

package dtcf_pkg;

   // Character store geometry
   localparam int BUFFER_DEPTH = 4096;
   localparam int IDX_W        = $clog2(BUFFER_DEPTH);
   localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
   localparam int FILL_W       = 13;

   // Command queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_IDX_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Command codes
   localparam logic [2:0] CMD_CHAR  = 3'd0;
   localparam logic [2:0] CMD_DIGIT = 3'd1;
   localparam logic [2:0] CMD_BYTE  = 3'd2;
   localparam logic [2:0] CMD_HEX16 = 3'd3;
   localparam logic [2:0] CMD_HEX32 = 3'd4;
   localparam logic [2:0] CMD_DRAIN = 3'd5;

   // Characters
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_X       = 8'h78;
   localparam logic [7:0] CH_UPPER_A = 8'h41;

   // Prefix phases: characters of "0x" still to emit
   localparam logic [1:0] PRE_NONE = 2'd0;
   localparam logic [1:0] PRE_X    = 2'd1;
   localparam logic [1:0] PRE_BOTH = 2'd2;

   // Work plan for one item, built by the front and carried out by the back
   typedef struct packed {
      logic        drain;   // pop one character
      logic        cr;      // emit a carriage return first
      logic        raw;     // emit chr as is
      logic [1:0]  pre;     // "0x" characters left
      logic [3:0]  dig;     // hex digits left
      logic [7:0]  chr;     // raw character
      logic [31:0] nib;     // digits, most significant nibble at the top
   } desc_type;

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return CH_ZERO + {4'b0000, n};
      end else begin
         return CH_UPPER_A + {4'b0000, n} - 8'd10;
      end
   endfunction

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

endpackage

`default_nettype wire

/* src/debug_trace_char_fifo.sv */
// Top level of the debug trace character FIFO: command front end, queue and store back end.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  req_command[2:0], req_value[31:0]
//   rsp_      out        rsp_valid/rsp_ready  rsp_drained_char[7:0], rsp_drained_valid,
//                                             rsp_fill_level[12:0]
//
// Each transfer on req_ yields exactly one transfer on rsp_, in order.
// The back end takes each push plan through idle, emit (N characters, up to
// 10 for a 32-bit value) and finish; a drain or an unused code skips emit.
// The single write port of the character store sets the one-character-per-cycle pace.
// Synchronous active-high reset empties the store pointers, the fill count and
// the two-entry command queue; store contents are not cleared.
// Unless full, the queue accepts while the back end works or a result waits on rsp_ready.
`default_nettype none

module debug_trace_char_fifo import dtcf_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [2:0]        req_command,
   input  wire logic [31:0]       req_value,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [7:0]        rsp_drained_char,
   output      logic              rsp_drained_valid,
   output      logic [FILL_W-1:0] rsp_fill_level
);

   // Plan handoff between front and back
   logic     desc_valid;
   desc_type desc;
   logic     desc_pop;

   // Decode commands into character plans and hold up to two of them
   dtcf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_value   (req_value),
      .desc_valid  (desc_valid),
      .desc        (desc),
      .desc_pop    (desc_pop)
   );

   // Advance through each plan one character per cycle, drop characters when
   // the store is full, and register the result
   dtcf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .desc_valid        (desc_valid),
      .desc              (desc),
      .desc_pop          (desc_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drained_char  (rsp_drained_char),
      .rsp_drained_valid (rsp_drained_valid),
      .rsp_fill_level    (rsp_fill_level)
   );

endmodule

`default_nettype wire

/* src/dtcf_front.sv */
// Front end: classifies incoming commands into work plans and queues them.
`default_nettype none

module dtcf_front import dtcf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [2:0]  req_command,
   input  wire logic [31:0] req_value,
   output      logic        desc_valid,
   output      desc_type    desc,
   input  wire logic        desc_pop
);

   desc_type             plan;
   desc_type             q_mem_ff [Q_DEPTH];
   logic [Q_IDX_W-1:0]   head_ff, head_in;
   logic [Q_IDX_W-1:0]   tail_ff, tail_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                 push;
   logic                 pop;

   // Classify the command into a character plan
   always_comb begin
      plan = '0;
      case (req_command)
         CMD_CHAR: begin
            plan.raw = 1'b1;
            plan.chr = req_value[7:0];
            plan.cr  = (req_value[7:0] == CH_LF);
         end
         CMD_DIGIT: begin
            plan.dig = 4'd1;
            plan.nib = {req_value[3:0], 28'd0};
         end
         CMD_BYTE: begin
            plan.dig = 4'd2;
            plan.nib = {req_value[7:0], 24'd0};
         end
         CMD_HEX16: begin
            plan.pre = PRE_BOTH;
            plan.dig = 4'd4;
            plan.nib = {req_value[15:0], 16'd0};
         end
         CMD_HEX32: begin
            plan.pre = PRE_BOTH;
            plan.dig = 4'd8;
            plan.nib = req_value;
         end
         CMD_DRAIN: begin
            plan.drain = 1'b1;
         end
         default: begin
            plan = '0;
         end
      endcase
   end

   assign req_ready  = (cnt_ff != Q_CNT_W'(Q_DEPTH));
   assign push       = req_valid && req_ready;
   assign desc_valid = (cnt_ff != '0);
   assign pop        = desc_pop && desc_valid;
   assign desc       = q_mem_ff[head_ff];

   always_comb begin
      head_in = pop  ? head_ff + 1'b1 : head_ff;
      tail_in = push ? tail_ff + 1'b1 : tail_ff;
      cnt_in  = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[tail_ff] <= plan;
      end
   end

endmodule

`default_nettype wire

/* src/dtcf_back.sv */
// Back end: writes planned characters into the ring store, drains it, builds results.
`default_nettype none

module dtcf_back import dtcf_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              desc_valid,
   input  wire desc_type          desc,
   output      logic              desc_pop,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [7:0]        rsp_drained_char,
   output      logic              rsp_drained_valid,
   output      logic [FILL_W-1:0] rsp_fill_level
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   desc_type           work_ff, work_in;
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               got_ff, got_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_char_ff, rsp_char_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [FILL_W-1:0]  rsp_fill_ff, rsp_fill_in;

   logic [7:0]         char_store [BUFFER_DEPTH];
   logic [7:0]         rd_data_ff;
   logic               mem_we;
   logic [7:0]         mem_wdata;
   logic               rd_en;

   desc_type           step;
   logic [7:0]         step_char;
   logic               full;
   logic               out_free;

   assign full     = (count_ff == CNT_W'(BUFFER_DEPTH));
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Pick the next character of the plan and retire it
   always_comb begin
      step      = work_ff;
      step_char = CH_CR;
      if (work_ff.cr) begin
         step.cr   = 1'b0;
         step_char = CH_CR;
      end else if (work_ff.raw) begin
         step.raw  = 1'b0;
         step_char = work_ff.chr;
      end else if (work_ff.pre == PRE_BOTH) begin
         step.pre  = PRE_X;
         step_char = CH_ZERO;
      end else if (work_ff.pre == PRE_X) begin
         step.pre  = PRE_NONE;
         step_char = CH_X;
      end else begin
         step.dig  = work_ff.dig - 4'd1;
         step.nib  = {work_ff.nib[27:0], 4'd0};
         step_char = hex_char(work_ff.nib[31:28]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      got_in       = got_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_fill_in  = rsp_fill_ff;
      desc_pop     = 1'b0;
      mem_we       = 1'b0;
      mem_wdata    = step_char;
      rd_en        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (desc_valid) begin
               desc_pop = 1'b1;
               work_in  = desc;
               got_in   = 1'b0;
               if (desc.drain) begin
                  state_in = ST_FINISH;
                  if (count_ff != '0) begin
                     rd_en     = 1'b1;
                     got_in    = 1'b1;
                     rd_ptr_in = next_idx(rd_ptr_ff);
                     count_in  = count_ff - 1'b1;
                  end
               end else if (desc.cr || desc.raw || desc.pre != PRE_NONE
                            || desc.dig != 4'd0) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_EMIT: begin
            work_in = step;
            if (!full) begin
               mem_we    = 1'b1;
               wr_ptr_in = next_idx(wr_ptr_ff);
               count_in  = count_ff + 1'b1;
            end
            if (!step.cr && !step.raw && step.pre == PRE_NONE && step.dig == 4'd0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = got_ff ? rd_data_ff : 8'd0;
               rsp_ok_in    = got_ff;
               rsp_fill_in  = FILL_W'(count_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         got_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         got_ff       <= got_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff     <= work_in;
      rsp_char_ff <= rsp_char_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_fill_ff <= rsp_fill_in;
   end

   // Character store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         char_store[wr_ptr_ff] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= char_store[rd_ptr_ff];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drained_char  = rsp_char_ff;
   assign rsp_drained_valid = rsp_ok_ff;
   assign rsp_fill_level    = rsp_fill_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(BUFFER_DEPTH))
      else $error("fill count above store depth");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !full)
      else $error("store written while full");

   a_no_read_empty: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> count_ff != '0)
      else $error("store read while empty");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff) && !$past(reset)) |->
         ($past(state_ff) == ST_FINISH && state_ff == ST_IDLE))
      else $error("result loaded outside finish state");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the debug trace character FIFO: table-driven and random traffic.
module testbench import dtcf_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // Codes the block must ignore
   localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
   localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

   // Random traffic size, near-full run, idle watchdog, settle time at the end, report limit
   localparam int RANDOM_ITEMS   = 1380;
   localparam int NEAR_FULL_RUN  = 300;
   localparam int IDLE_LIMIT     = 2000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int REPORT_LIMIT   = 40;

   // Receiver stall modes
   localparam logic [1:0] RDY_ALWAYS = 2'd0;
   localparam logic [1:0] RDY_MOSTLY = 2'd1;
   localparam logic [1:0] RDY_RUNS   = 2'd2;
   localparam logic [1:0] RDY_SPARSE = 2'd3;

   // Random traffic phases: fill up, hover at full, then mostly drain
   typedef enum logic [1:0] {PH_FILL, PH_NEAR_FULL, PH_MIXED} traffic_phase_type;

   typedef struct packed {
      logic [7:0]        drained_char;
      logic              drained_valid;
      logic [FILL_W-1:0] fill_level;
   } fifo_result_type;

   typedef struct packed {
      logic [2:0]      cmd;
      logic [31:0]     val;
      logic            typed;   // row carries its own expected result
      fifo_result_type res;
   } trace_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [2:0]        req_command = CMD_DRAIN;
   logic [31:0]       req_value = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [7:0]        rsp_drained_char;
   logic              rsp_drained_valid;
   logic [FILL_W-1:0] rsp_fill_level;

   debug_trace_char_fifo DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drained_char  (rsp_drained_char),
      .rsp_drained_valid (rsp_drained_valid),
      .rsp_fill_level    (rsp_fill_level)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Character store mirror: a ring of BUFFER_DEPTH characters with its own
   // put/take pointers and a count of held characters.
   // ---------------------------------------------------------------------
   logic [7:0]       trace_store [BUFFER_DEPTH];
   logic [IDX_W-1:0] put_ptr  = '0;
   logic [IDX_W-1:0] take_ptr = '0;
   int               held_chars = 0;

   // Run statistics
   int dropped_chars = 0;
   int peak_fill     = 0;
   int put_wraps     = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int error_count   = 0;

   fifo_result_type fill_results [$];   // expected results, oldest first

   function automatic logic [IDX_W-1:0] ring_step(input logic [IDX_W-1:0] p);
      return (p == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Store one character unless the ring is full; a full ring drops it.
   function automatic void store_char(input logic [7:0] ch);
      if (held_chars >= BUFFER_DEPTH) begin
         dropped_chars++;
      end else begin
         trace_store[put_ptr] = ch;
         if (put_ptr == IDX_W'(BUFFER_DEPTH - 1)) begin
            put_wraps++;
         end
         put_ptr = ring_step(put_ptr);
         held_chars++;
         if (held_chars > peak_fill) begin
            peak_fill = held_chars;
         end
      end
   endfunction

   // A newline goes in as CR then LF, each checked against the room left.
   function automatic void push_char(input logic [7:0] ch);
      if (ch == CH_LF) begin
         store_char(CH_CR);
      end
      store_char(ch);
   endfunction

   function automatic void push_nibble(input logic [3:0] nib);
      string glyphs;
      glyphs = "0123456789ABCDEF";
      push_char(glyphs[nib]);
   endfunction

   // Format the low digits of v, most significant first, with optional "0x".
   function automatic void push_hex(input logic [31:0] v, input int digits, input bit prefix);
      if (prefix) begin
         push_char(CH_ZERO);
         push_char(CH_X);
      end
      for (int k = digits - 1; k >= 0; k--) begin
         push_nibble(v[4*k +: 4]);
      end
   endfunction

   // Apply one command to the mirror and return the result it should give.
   function automatic fifo_result_type apply_trace_cmd(input logic [2:0] cmd,
                                                       input logic [31:0] val);
      fifo_result_type r;
      r = '0;
      case (cmd)
         CMD_CHAR:  push_char(val[7:0]);
         CMD_DIGIT: push_nibble(val[3:0]);
         CMD_BYTE:  push_hex(val, 2, 1'b0);
         CMD_HEX16: push_hex(val, 4, 1'b1);
         CMD_HEX32: push_hex(val, 8, 1'b1);
         CMD_DRAIN: begin
            if (held_chars > 0) begin
               r.drained_char  = trace_store[take_ptr];
               r.drained_valid = 1'b1;
               take_ptr        = ring_step(take_ptr);
               held_chars--;
            end
         end
         default: ;
      endcase
      r.fill_level = FILL_W'(held_chars);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Directed table: after reset, ignored codes, newline expansion, the
   // extremes of every push and of every hex digit. Rows with typed set
   // carry a result that is obvious by hand; the rest use the mirror.
   // ---------------------------------------------------------------------
   localparam int DIRECTED_ROWS = 25;
   localparam trace_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{CMD_DRAIN,    32'h0000_0000,          1'b1, '{8'h00,      1'b0, FILL_W'(0)}},
      '{CMD_UNUSED_6, 32'hFFFF_FFFF,          1'b1, '{8'h00,      1'b0, FILL_W'(0)}},
      '{CMD_UNUSED_7, 32'h0000_0000,          1'b1, '{8'h00,      1'b0, FILL_W'(0)}},
      '{CMD_CHAR,     {24'hFFFFFF, CH_UPPER_A}, 1'b1, '{8'h00,    1'b0, FILL_W'(1)}},
      '{CMD_DRAIN,    32'h0000_0000,          1'b1, '{CH_UPPER_A, 1'b1, FILL_W'(0)}},
      '{CMD_CHAR,     {24'h000000, CH_LF},    1'b1, '{8'h00,      1'b0, FILL_W'(2)}},
      '{CMD_DRAIN,    32'h0000_0000,          1'b1, '{CH_CR,      1'b1, FILL_W'(1)}},
      '{CMD_DRAIN,    32'h0000_0000,          1'b1, '{CH_LF,      1'b1, FILL_W'(0)}},
      '{CMD_CHAR,     32'h0000_0000,          1'b1, '{8'h00,      1'b0, FILL_W'(1)}},
      '{CMD_CHAR,     32'h0000_00FF,          1'b1, '{8'h00,      1'b0, FILL_W'(2)}},
      '{CMD_DIGIT,    32'hFFFF_FFF0,          1'b0, '0},
      '{CMD_DIGIT,    32'h0000_0009,          1'b0, '0},
      '{CMD_DIGIT,    32'h0000_000A,          1'b0, '0},
      '{CMD_DIGIT,    32'h0000_000F,          1'b0, '0},
      '{CMD_BYTE,     32'h0000_0000,          1'b0, '0},
      '{CMD_BYTE,     32'hFFFF_FFFF,          1'b0, '0},
      '{CMD_HEX16,    32'h0000_0000,          1'b0, '0},
      '{CMD_HEX16,    32'h1234_FFFF,          1'b0, '0},
      '{CMD_HEX32,    32'h0000_0000,          1'b0, '0},
      '{CMD_HEX32,    32'hFFFF_FFFF,          1'b0, '0},
      '{CMD_HEX32,    32'h89AB_CDEF,          1'b0, '0},
      '{CMD_CHAR,     {24'h5A5A5A, CH_CR},    1'b0, '0},
      '{CMD_DRAIN,    32'h0000_0000,          1'b0, '0},
      '{CMD_DRAIN,    32'hFFFF_FFFF,          1'b0, '0},
      '{CMD_DRAIN,    32'h0000_0000,          1'b0, '0}
   };

   // ---------------------------------------------------------------------
   // Sender helpers
   // ---------------------------------------------------------------------
   int burst_left = 0;

   // Drive one item and hold it until the transfer; queue its result first.
   task automatic send_item(input logic [2:0] cmd, input logic [31:0] val,
                            input logic typed, input fifo_result_type typed_res);
      fifo_result_type want;
      want = apply_trace_cmd(cmd, val);
      if (typed) begin
         want = typed_res;
      end
      fill_results.push_back(want);
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_value   <= val;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   // Between bursts drop valid for a random gap; some bursts run long with
   // no gap at all.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
      end
   endtask

   // Hold valid low until every queued result has come back. The queue is
   // looked at on the falling edge, clear of the monitor's rising-edge pop.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (fill_results.size() != 0);
      @(posedge clock);
   endtask

   // Pick a random push command; one raw char in ten is a newline.
   task automatic pick_push(output logic [2:0] cmd, output logic [31:0] val);
      int roll;
      roll = $urandom_range(0, 99);
      val  = $urandom();
      if (roll < 15) begin
         cmd = CMD_CHAR;
         if ($urandom_range(0, 9) == 0) begin
            val[7:0] = CH_LF;
         end
      end else if (roll < 25) begin
         cmd = CMD_DIGIT;
      end else if (roll < 40) begin
         cmd = CMD_BYTE;
      end else if (roll < 60) begin
         cmd = CMD_HEX16;
      end else begin
         cmd = CMD_HEX32;
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver: ready follows a mode that changes at random intervals:
   // always ready, mostly ready, runs of ready and stall, mostly stalled.
   // ---------------------------------------------------------------------
   logic [1:0] ready_mode      = RDY_ALWAYS;
   int         ready_mode_left = 0;
   int         ready_run_left  = 0;

   always @(posedge clock) begin
      if (ready_mode_left == 0) begin
         ready_mode      <= 2'($urandom_range(0, 3));
         ready_mode_left <= $urandom_range(50, 300);
      end else begin
         ready_mode_left <= ready_mode_left - 1;
      end
      if (ready_run_left == 0) begin
         ready_run_left <= rsp_ready ? $urandom_range(1, 16) : $urandom_range(1, 10);
      end else begin
         ready_run_left <= ready_run_left - 1;
      end
      case (ready_mode)
         RDY_ALWAYS: rsp_ready <= 1'b1;
         RDY_MOSTLY: rsp_ready <= ($urandom_range(0, 9) < 7);
         RDY_RUNS:   rsp_ready <= (ready_run_left == 0) ? ~rsp_ready : rsp_ready;
         RDY_SPARSE: rsp_ready <= ($urandom_range(0, 9) < 3);
         default:    rsp_ready <= 1'b1;
      endcase
   end

   // ---------------------------------------------------------------------
   // Result checker: every rsp_ transfer is matched with the oldest
   // expected result, field by field.
   // ---------------------------------------------------------------------
   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("%0t ns: result %0d %s mismatch: expected 0x%0h, actual 0x%0h",
                  $realtime, results_seen, field, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      fifo_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (fill_results.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("%0t ns: result with nothing expected: char 0x%0h valid %0b fill %0d",
                        $realtime, rsp_drained_char, rsp_drained_valid, rsp_fill_level);
            end
         end else begin
            want = fill_results.pop_front();
            if (rsp_drained_char !== want.drained_char) begin
               report_field("drained_char", 32'(want.drained_char),
                            32'(rsp_drained_char));
            end
            if (rsp_drained_valid !== want.drained_valid) begin
               report_field("drained_valid", 32'(want.drained_valid),
                            32'(rsp_drained_valid));
            end
            if (rsp_fill_level !== want.fill_level) begin
               report_field("fill_level", 32'(want.fill_level), 32'(rsp_fill_level));
            end
         end
         results_seen++;
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: too many cycles with no transfer on either channel ends
   // the run as a failure.
   // ---------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                  $realtime, IDLE_LIMIT, fill_results.size());
         $display("testbench: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      traffic_phase_type phase;
      int                counted;
      int                phase_items;
      int                roll;
      logic [2:0]        cmd;
      logic [31:0]       val;

      // Hold reset from the start, then release it at a rising edge.
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         pace_sender();
         send_item(DIRECTED[i].cmd, DIRECTED[i].val, DIRECTED[i].typed, DIRECTED[i].res);
      end

      // Let the block go fully idle before the random traffic starts.
      hold_until_drained();

      // Random traffic. Fill the ring first, then hover at full so that
      // characters get dropped and the write side wraps, then mix mostly
      // drains with pushes. Ignored codes are sprinkled in everywhere but do
      // not count toward the item total.
      phase       = PH_FILL;
      counted     = 0;
      phase_items = 0;
      while (counted < RANDOM_ITEMS) begin
         if (phase == PH_FILL && held_chars >= BUFFER_DEPTH) begin
            phase       = PH_NEAR_FULL;
            phase_items = 0;
            hold_until_drained();
         end else if (phase == PH_NEAR_FULL && phase_items >= NEAR_FULL_RUN) begin
            phase       = PH_MIXED;
            phase_items = 0;
            hold_until_drained();
         end else begin
            pace_sender();
         end

         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            cmd = (roll == 0) ? CMD_UNUSED_6 : CMD_UNUSED_7;
            val = $urandom();
         end else begin
            case (phase)
               PH_FILL: begin
                  if (roll < 12) begin
                     cmd = CMD_DRAIN;
                     val = $urandom();
                  end else begin
                     pick_push(cmd, val);
                  end
               end
               PH_NEAR_FULL: begin
                  // With one slot or none left, a newline splits or drops whole.
                  if (held_chars >= BUFFER_DEPTH - 1 && roll < 40) begin
                     cmd = CMD_CHAR;
                     val = {24'($urandom_range(0, 32'hFFFFFF)), CH_LF};
                  end else if (roll < 45) begin
                     cmd = CMD_DRAIN;
                     val = $urandom();
                  end else begin
                     pick_push(cmd, val);
                  end
               end
               default: begin
                  if (roll < 70) begin
                     cmd = CMD_DRAIN;
                     val = $urandom();
                  end else begin
                     pick_push(cmd, val);
                  end
               end
            endcase
         end

         send_item(cmd, val, 1'b0, '0);
         if (cmd != CMD_UNUSED_6 && cmd != CMD_UNUSED_7) begin
            counted++;
            phase_items++;
         end
      end

      // Drop valid, wait for the last results, then give the block time to
      // show any stray transfer.
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fill_results.size() != 0) begin
         error_count++;
         $display("%0t ns: %0d expected results never arrived", $realtime, fill_results.size());
      end

      $display("run covered %0d items and %0d checked results; fill peaked at %0d",
               items_sent, results_seen, peak_fill);
      $display("run dropped %0d characters on a full ring; write side wrapped %0d times",
               dropped_chars, put_wraps);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

/* sim.f */
src/dtcf_pkg.sv
src/dtcf_front.sv
src/dtcf_back.sv
src/debug_trace_char_fifo.sv
tb/testbench.sv
